>>> hdl/lrc_pkg.sv
`default_nettype none
package lrc_pkg;
	localparam int ENTRIES_DEF  = 64;
	localparam int ROW_BITS_DEF = 32;
	localparam int MIN_LIMIT    = 2;
	localparam int LIMIT_W      = 7;
	localparam int IDX_W        = 6;
	localparam int SCR_W        = 8;
	localparam int FLD_W        = 32;
	localparam int SY_W         = 16;
	localparam int NODE_W       = 16;
	localparam int IN_W         = 144;
	localparam int OUT_W        = 32;

	localparam logic [2:0] OP_ACCESS = 3'd0;
	localparam logic [2:0] OP_INVAL  = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_CONT   = 3'd3;
	localparam logic [2:0] OP_VLOOK  = 3'd4;
	localparam logic [2:0] OP_VSET   = 3'd5;

	// per-entry command from sequencer to the entry array
	typedef struct packed {
		logic       clear;   // drop every entry
		logic       evict;   // drop the entry whose rank is count-1
		logic       promote; // move hit entry to front
		logic       insert;  // shift all ranks, fill free slot at rank 0
		logic       inval;   // set dirty marks on range match
	} ecmd_t;

	typedef struct packed {
		logic hit;
		logic any_match;
		logic full_free;     // a free slot exists
	} estat_t;
endpackage
`default_nettype wire

>>> hdl/lrc_entries.sv
`default_nettype none
module lrc_entries #(
	parameter int ENTRIES  = lrc_pkg::ENTRIES_DEF,
	parameter int ROW_BITS = lrc_pkg::ROW_BITS_DEF,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW = $clog2(ENTRIES + 1)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire lrc_pkg::ecmd_t            cmd,
	input  wire [lrc_pkg::SCR_W-1:0]       scr,
	input  wire [ROW_BITS-1:0]             row,
	input  wire [ROW_BITS-1:0]             first,
	input  wire [ROW_BITS-1:0]             last,
	input  wire [1:0]                      parts,
	output lrc_pkg::estat_t                stat,
	output logic [IW-1:0]                  hit_idx,
	output logic [IW-1:0]                  free_idx,
	output logic                           hit_bg,
	output logic                           hit_fg,
	output logic [CW-1:0]                  count
);
	logic [ENTRIES-1:0] valid_q;
	logic [lrc_pkg::SCR_W-1:0] scr_q [ENTRIES];
	logic [ROW_BITS-1:0] row_q [ENTRIES];
	logic [ENTRIES-1:0] bg_q, fg_q;
	logic [IW-1:0] rank_q [ENTRIES];
	logic [CW-1:0] count_q;
	logic [ENTRIES-1:0] hitv, rngv, oldv, freev;
	logic [IW-1:0] hit_rank;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hitv[i]  = valid_q[i] && scr_q[i] == scr && row_q[i] == row;
			rngv[i]  = valid_q[i] && scr_q[i] == scr && row_q[i] >= first &&
				row_q[i] <= last;
			oldv[i]  = valid_q[i] && CW'(rank_q[i]) == count_q - CW'(1);
			freev[i] = !valid_q[i];
		end
		hit_idx = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hitv[i])  hit_idx  = IW'(i);
			if (freev[i]) free_idx = IW'(i);
		end
	end

	assign hit_rank = rank_q[hit_idx];
	assign hit_bg = bg_q[hit_idx];
	assign hit_fg = fg_q[hit_idx];
	assign stat.hit = |hitv;
	assign stat.any_match = |rngv;
	assign stat.full_free = |freev;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.evict) begin
			if (|oldv) begin
				valid_q <= valid_q & ~oldv;
				count_q <= count_q - CW'(1);
			end
		end else if (cmd.insert) begin
			valid_q[free_idx] <= 1'b1;
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.promote && valid_q[i] && rank_q[i] < hit_rank)
				rank_q[i] <= rank_q[i] + IW'(1);
			if (cmd.insert && valid_q[i])
				rank_q[i] <= rank_q[i] + IW'(1);
			if (cmd.inval && rngv[i]) begin
				if (parts[0]) bg_q[i] <= 1'b1;
				if (parts[1]) fg_q[i] <= 1'b1;
			end
		end
		if (cmd.promote)
			rank_q[hit_idx] <= '0;
		if (cmd.insert) begin
			scr_q[free_idx]  <= scr;
			row_q[free_idx]  <= row;
			bg_q[free_idx]   <= 1'b1;
			fg_q[free_idx]   <= 1'b1;
			rank_q[free_idx] <= '0;
		end
	end
endmodule
`default_nettype wire

>>> hdl/lru_row_cache_range_invalidate_unit.sv
`default_nettype none
// Flow: accept, execute, then the result is offered for hits, views,
// invalidation and clear; an access miss adds an insert step, preceded
// by eviction of the oldest entry when the cache is at its limit. A limit
// write evicts 1 entry per cycle while idle, before the next request is
// accepted. One request at a time; an output stall holds the unit.
// Reset (arst_n low): cache and both viewports empty, row_limit = ENTRIES.
module lru_row_cache_range_invalidate_unit #(
	parameter int ENTRIES  = lrc_pkg::ENTRIES_DEF,
	parameter int ROW_BITS = lrc_pkg::ROW_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_axis_tvalid,
	output logic                      s_axis_tready,
	// operation, screen_id, row_number, first_row, last_row, parts, start_y,
	// blink, node_handle
	input  wire [lrc_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  wire                       m_axis_tready,
	// hit, entry_index, bg dirty mark, fg dirty mark, node_handle_out
	output logic [lrc_pkg::OUT_W-1:0] m_axis_tdata,
	input  wire                       row_limit_we,
	input  wire [lrc_pkg::LIMIT_W-1:0] row_limit_wdata
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_EXEC = 4'b0010,
		ST_OUT  = 4'b0100, ST_INS  = 4'b1000
	} st_t;
	st_t st_q;

	logic [lrc_pkg::IN_W-1:0] req_q;
	logic [CW-1:0] limit_q;
	logic [lrc_pkg::OUT_W-1:0] res_q;

	wire [2:0] op = req_q[2:0];
	wire [lrc_pkg::SCR_W-1:0] scr = req_q[10:3];
	wire [ROW_BITS-1:0] row   = ROW_BITS'(req_q[42:11]);
	wire [ROW_BITS-1:0] first = ROW_BITS'(req_q[74:43]);
	wire [ROW_BITS-1:0] last  = ROW_BITS'(req_q[106:75]);
	wire [1:0] parts = req_q[108:107];
	wire [15:0] sy = req_q[124:109];
	wire sel = req_q[125];
	wire [15:0] node = req_q[141:126];

	logic [1:0] vv_q;
	logic [lrc_pkg::SCR_W-1:0] vscr_q [2];
	logic [ROW_BITS-1:0] vfirst_q [2], vlast_q [2];
	logic [15:0] vsy_q [2], vnode_q [2];

	lrc_pkg::ecmd_t cmd;
	lrc_pkg::estat_t stat;
	logic [IW-1:0] hit_idx, free_idx;
	logic hit_bg, hit_fg;
	logic [CW-1:0] count;

	lrc_entries #(.ENTRIES(ENTRIES), .ROW_BITS(ROW_BITS)) u_ent (
		.clk, .arst_n, .cmd, .scr, .row, .first, .last, .parts, .stat,
		.hit_idx, .free_idx, .hit_bg, .hit_fg, .count
	);

	// clamp written limit into [2, ENTRIES]
	logic [CW-1:0] lim_c;
	always_comb begin
		if (row_limit_wdata < lrc_pkg::LIMIT_W'(lrc_pkg::MIN_LIMIT))
			lim_c = CW'(lrc_pkg::MIN_LIMIT);
		else if ({25'd0, row_limit_wdata} > 32'(ENTRIES))
			lim_c = CW'(ENTRIES);
		else
			lim_c = CW'(row_limit_wdata);
	end

	wire vmatch = vv_q[sel] && vscr_q[sel] == scr && vfirst_q[sel] == first &&
		vlast_q[sel] == last && vsy_q[sel] == sy;
	wire inval_go = op == lrc_pkg::OP_INVAL && last >= first && parts != 2'd0;
	wire acc = op == lrc_pkg::OP_ACCESS;

	always_comb begin
		cmd = '0;
		case (st_q)
			ST_EXEC: begin
				cmd.clear   = op == lrc_pkg::OP_CLEAR;
				cmd.promote = acc && stat.hit;
				cmd.inval   = inval_go;
			end
			ST_INS:  cmd.evict = count >= limit_q;
			ST_OUT:  cmd.insert = 1'b0;
			default: cmd = '0;
		endcase
		if (st_q == ST_INS && count < limit_q) cmd.insert = 1'b1;
		if (st_q == ST_IDLE && count > limit_q) cmd.evict = 1'b1;
	end

	assign s_axis_tready = st_q == ST_IDLE && count <= limit_q;
	assign m_axis_tvalid = st_q == ST_OUT;
	assign m_axis_tdata = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			limit_q <= CW'(ENTRIES);
			vv_q <= '0;
		end else begin
			if (row_limit_we) limit_q <= lim_c;
			case (st_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) st_q <= ST_EXEC;
				ST_EXEC: begin
					if (acc && !stat.hit) st_q <= ST_INS;
					else st_q <= ST_OUT;
					if (op == lrc_pkg::OP_CLEAR) vv_q <= '0;
					if (inval_go && stat.any_match) vv_q <= '0;
					if (op == lrc_pkg::OP_VSET) vv_q[sel] <= 1'b1;
				end
				ST_INS: if (count < limit_q) st_q <= ST_OUT;
				ST_OUT: if (m_axis_tready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) req_q <= s_axis_tdata;
		if (st_q == ST_EXEC) begin
			if (op == lrc_pkg::OP_VSET) begin
				vscr_q[sel] <= scr;
				vfirst_q[sel] <= first;
				vlast_q[sel] <= last;
				vsy_q[sel] <= sy;
				vnode_q[sel] <= node;
			end
			if ((acc || op == lrc_pkg::OP_CONT) && stat.hit)
				res_q <= lrc_pkg::OUT_W'({hit_fg, hit_bg, 6'(hit_idx), 1'b1});
			else if (op == lrc_pkg::OP_VLOOK && vmatch)
				res_q <= lrc_pkg::OUT_W'({vnode_q[sel], 8'd0, 1'b1});
			else
				res_q <= '0;
		end
		// free slot captured as the entry is written
		if (st_q == ST_INS && count < limit_q)
			res_q <= lrc_pkg::OUT_W'({2'b11, 6'(free_idx), 1'b0});
	end
endmodule
`default_nettype wire

>>> hdl/lrc_checker.sv
`default_nettype none
module lrc_checker (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	input wire s_axis_tready,
	input wire m_axis_tvalid,
	input wire m_axis_tready,
	input wire [lrc_pkg::OUT_W-1:0] m_axis_tdata
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("double accept");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_node: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[24:9] == 16'd0)
		else $error("handle on miss");
endmodule
bind lru_row_cache_range_invalidate_unit lrc_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
	.m_axis_tready, .m_axis_tdata
);
`default_nettype wire

>>> bench/lru_row_cache_range_invalidate_unit_tb.sv
`timescale 1ns / 1ps
module lru_row_cache_range_invalidate_unit_tb;
	localparam int N = lrc_pkg::ENTRIES_DEF;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	// operation, screen_id, row_number, first_row, last_row, parts, start_y,
	// blink, node_handle
	logic [lrc_pkg::IN_W-1:0]    s_axis_tdata = '0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	// hit, entry_index, bg dirty mark, fg dirty mark, node_handle_out
	logic [lrc_pkg::OUT_W-1:0]   m_axis_tdata;
	logic                        row_limit_we = 1'b0;
	logic [lrc_pkg::LIMIT_W-1:0] row_limit_wdata = '0;

	lru_row_cache_range_invalidate_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.row_limit_we(row_limit_we), .row_limit_wdata(row_limit_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// cache image
	logic        c_valid [N];
	logic [7:0]  c_scr [N];
	logic [31:0] c_row [N];
	logic        c_bg [N];
	logic        c_fg [N];
	int          c_rank [N];
	int          c_count;
	int          c_limit;
	logic        v_valid [2];
	logic [7:0]  v_scr [2];
	logic [31:0] v_first [2];
	logic [31:0] v_last [2];
	logic [15:0] v_sy [2];
	logic [15:0] v_node [2];

	logic [31:0] expected_q [$];
	int          err_cnt = 0;
	int          burst_left = 0;

	// most recent view keys so view lookups can match
	logic [7:0]  last_scr = 8'd0;
	logic [31:0] last_first = 32'd0, last_last = 32'd0;
	logic [15:0] last_sy = 16'd0;

	function automatic logic [lrc_pkg::IN_W-1:0] pack_req(logic [2:0] op,
		logic [7:0] scr, logic [31:0] row, logic [31:0] first, logic [31:0] last,
		logic [1:0] parts, logic [15:0] sy, logic blink, logic [15:0] node);
		logic [lrc_pkg::IN_W-1:0] d;
		d = '0;
		d[2:0] = op;
		d[10:3] = scr;
		d[42:11] = row;
		d[74:43] = first;
		d[106:75] = last;
		d[108:107] = parts;
		d[124:109] = sy;
		d[125] = blink;
		d[141:126] = node;
		return d;
	endfunction

	function automatic int find_slot(logic [7:0] scr, logic [31:0] row);
		for (int i = 0; i < N; i++)
			if (c_valid[i] && c_scr[i] == scr && c_row[i] == row)
				return i;
		return -1;
	endfunction

	task automatic drop_oldest();
		if (c_count == 0)
			return;
		for (int i = 0; i < N; i++) begin
			if (c_valid[i] && c_rank[i] == c_count - 1) begin
				c_valid[i] = 1'b0;
				c_count--;
				return;
			end
		end
	endtask

	task automatic cache_reset();
		for (int i = 0; i < N; i++)
			c_valid[i] = 1'b0;
		c_count = 0;
		c_limit = N;
		v_valid[0] = 1'b0;
		v_valid[1] = 1'b0;
	endtask

	// compute the result of one request and update the image
	task automatic predict_result(logic [lrc_pkg::IN_W-1:0] d);
		logic [2:0]  op;
		logic [7:0]  scr;
		logic [31:0] row, first, last;
		logic [1:0]  parts;
		logic [15:0] sy, node;
		logic        sel, hit, bg, fg, any;
		logic [5:0]  idx;
		logic [15:0] nout;
		int          s, r;
		op = d[2:0]; scr = d[10:3]; row = d[42:11]; first = d[74:43];
		last = d[106:75]; parts = d[108:107]; sy = d[124:109]; sel = d[125];
		node = d[141:126];
		hit = 0; idx = 0; bg = 0; fg = 0; nout = 0;
		case (op)
			lrc_pkg::OP_ACCESS: begin
				s = find_slot(scr, row);
				if (s >= 0) begin
					hit = 1;
					r = c_rank[s];
					for (int i = 0; i < N; i++)
						if (c_valid[i] && c_rank[i] < r)
							c_rank[i]++;
					c_rank[s] = 0;
				end else begin
					while (c_count >= c_limit)
						drop_oldest();
					s = 0;
					for (int i = N - 1; i >= 0; i--)
						if (!c_valid[i])
							s = i;
					for (int i = 0; i < N; i++)
						if (c_valid[i])
							c_rank[i]++;
					c_valid[s] = 1; c_scr[s] = scr; c_row[s] = row;
					c_bg[s] = 1; c_fg[s] = 1; c_rank[s] = 0;
					c_count++;
				end
				idx = s[5:0]; bg = c_bg[s]; fg = c_fg[s];
			end
			lrc_pkg::OP_INVAL: begin
				if (!(last < first || parts == 2'd0)) begin
					any = 0;
					for (int i = 0; i < N; i++) begin
						if (c_valid[i] && c_scr[i] == scr && c_row[i] >= first &&
						    c_row[i] <= last) begin
							any = 1;
							if (parts[0]) c_bg[i] = 1;
							if (parts[1]) c_fg[i] = 1;
						end
					end
					if (any) begin
						v_valid[0] = 0;
						v_valid[1] = 0;
					end
				end
			end
			lrc_pkg::OP_CLEAR: cache_reset_keep_limit();
			lrc_pkg::OP_CONT: begin
				s = find_slot(scr, row);
				if (s >= 0) begin
					hit = 1; idx = s[5:0]; bg = c_bg[s]; fg = c_fg[s];
				end
			end
			lrc_pkg::OP_VLOOK: begin
				if (v_valid[sel] && v_scr[sel] == scr && v_first[sel] == first &&
				    v_last[sel] == last && v_sy[sel] == sy) begin
					hit = 1;
					nout = v_node[sel];
				end
			end
			lrc_pkg::OP_VSET: begin
				v_valid[sel] = 1; v_scr[sel] = scr; v_first[sel] = first;
				v_last[sel] = last; v_sy[sel] = sy; v_node[sel] = node;
			end
			default: ;
		endcase
		expected_q.push_back({7'd0, nout, fg, bg, idx, hit});
	endtask

	task automatic cache_reset_keep_limit();
		int keep;
		keep = c_limit;
		cache_reset();
		c_limit = keep;
	endtask

	// sender: bursts with random gaps
	task automatic send_req(logic [lrc_pkg::IN_W-1:0] d);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		predict_result(d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_limit(logic [lrc_pkg::LIMIT_W-1:0] v);
		int lim;
		wait_idle();
		row_limit_we <= 1'b1;
		row_limit_wdata <= v;
		@(posedge clk);
		row_limit_we <= 1'b0;
		lim = v;
		if (lim < lrc_pkg::MIN_LIMIT) lim = lrc_pkg::MIN_LIMIT;
		if (lim > N) lim = N;
		c_limit = lim;
		while (c_count > c_limit)
			drop_oldest();
		repeat (80) @(posedge clk);
	endtask

	// receiver stall pattern: phases of always-ready, light and heavy stalls
	int rx_phase = 0, rx_mode = 0;
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_phase <= $urandom_range(10, 80);
			rx_mode <= $urandom_range(0, 2);
		end else begin
			rx_phase <= rx_phase - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// result checker
	always @(negedge clk) begin
		logic [31:0] got, exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = 32'(m_axis_tdata);
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $realtime, got);
				err_cnt++;
			end else begin
				exp = expected_q.pop_front();
				if (got[0] !== exp[0]) begin
					$display("%0t: hit exp %h act %h", $realtime, exp[0], got[0]);
					err_cnt++;
				end
				if (got[6:1] !== exp[6:1]) begin
					$display("%0t: entry_index exp %0d act %0d", $realtime, exp[6:1],
						got[6:1]);
					err_cnt++;
				end
				if (got[7] !== exp[7]) begin
					$display("%0t: bg dirty exp %h act %h", $realtime, exp[7],
						got[7]);
					err_cnt++;
				end
				if (got[8] !== exp[8]) begin
					$display("%0t: fg dirty exp %h act %h", $realtime, exp[8],
						got[8]);
					err_cnt++;
				end
				if (got[24:9] !== exp[24:9]) begin
					$display("%0t: node_handle_out exp %h act %h", $realtime, exp[24:9],
						got[24:9]);
					err_cnt++;
				end
			end
		end
	end

	task automatic test_directed();
		send_req(pack_req(lrc_pkg::OP_ACCESS, 8'h00, 32'h0, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_ACCESS, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_ACCESS, 8'h00, 32'h0, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_CONT, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_CONT, 8'h12, 32'h5, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_VSET, 8'hFF, 0, 32'h0, 32'hFFFF_FFFF, 0, 16'h8000,
			0, 16'hFFFF));
		send_req(pack_req(lrc_pkg::OP_VSET, 8'h00, 0, 32'h10, 32'h20, 0, 16'h7FFF, 1,
			16'h1234));
		send_req(pack_req(lrc_pkg::OP_VLOOK, 8'hFF, 0, 32'h0, 32'hFFFF_FFFF, 0, 16'h8000,
			0, 0));
		send_req(pack_req(lrc_pkg::OP_VLOOK, 8'h00, 0, 32'h10, 32'h20, 0, 16'h7FFF, 1, 0));
		send_req(pack_req(lrc_pkg::OP_VLOOK, 8'h00, 0, 32'h10, 32'h20, 0, 16'h7FFE, 1, 0));
		// empty range and zero parts leave the views alone
		send_req(pack_req(lrc_pkg::OP_INVAL, 8'h00, 0, 32'h5, 32'h4, 2'd3, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_INVAL, 8'h00, 0, 32'h0, 32'hFFFF_FFFF, 2'd0, 0, 0,
			0));
		send_req(pack_req(lrc_pkg::OP_VLOOK, 8'h00, 0, 32'h10, 32'h20, 0, 16'h7FFF, 1, 0));
		send_req(pack_req(lrc_pkg::OP_INVAL, 8'h01, 0, 32'h0, 32'hFFFF_FFFF, 2'd1, 0, 0,
			0));
		send_req(pack_req(lrc_pkg::OP_INVAL, 8'hFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2,
			0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_VLOOK, 8'h00, 0, 32'h10, 32'h20, 0, 16'h7FFF, 1, 0));
		send_req(pack_req(lrc_pkg::OP_CONT, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(3'd6, 8'hFF, 32'hFFFF_FFFF, '1, '1, 2'd3, '1, 1, '1));
		send_req(pack_req(3'd7, 8'h00, 0, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_CONT, 8'h00, 32'h0, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(lrc_pkg::OP_VLOOK, 8'hFF, 0, 32'h0, 32'hFFFF_FFFF, 0, 16'h8000,
			0, 0));
	endtask

	function automatic logic [lrc_pkg::IN_W-1:0] rand_req();
		logic [2:0]  op;
		logic [7:0]  scr;
		logic [31:0] row, first, last;
		logic [15:0] sy;
		int          k;
		k = $urandom_range(0, 99);
		if (k < 45) op = lrc_pkg::OP_ACCESS;
		else if (k < 57) op = lrc_pkg::OP_CONT;
		else if (k < 69) op = lrc_pkg::OP_INVAL;
		else if (k < 79) op = lrc_pkg::OP_VSET;
		else if (k < 93) op = lrc_pkg::OP_VLOOK;
		else if (k < 96) op = lrc_pkg::OP_CLEAR;
		else op = 3'($urandom_range(6, 7));
		scr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		row = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
		if ($urandom_range(0, 9) == 0) begin
			first = $urandom;
			last = $urandom;
		end else begin
			first = $urandom_range(0, 40);
			last = first + $urandom_range(0, 10);
		end
		sy = 16'($urandom);
		if (op == lrc_pkg::OP_VLOOK && $urandom_range(0, 2) != 0) begin
			scr = last_scr; first = last_first; last = last_last; sy = last_sy;
		end
		if (op == lrc_pkg::OP_VSET) begin
			last_scr = scr; last_first = first; last_last = last; last_sy = sy;
		end
		return pack_req(op, scr, row, first, last, 2'($urandom), sy, 1'($urandom),
			16'($urandom));
	endfunction

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_req(rand_req());
	endtask

	initial begin
		cache_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		write_limit(7'd2);
		test_random(130);
		write_limit(7'd0);
		test_random(130);
		write_limit(7'd127);
		test_random(200);
		write_limit(7'd5);
		test_random(130);
		write_limit(7'd1);
		test_random(100);
		write_limit(7'd64);
		test_random(200);
		write_limit(7'd3);
		test_random(150);
		wait_idle();
		if (err_cnt == 0)
			$display("lru_row_cache_range_invalidate_unit_tb: clean");
		else
			$display("lru_row_cache_range_invalidate_unit_tb: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("lru_row_cache_range_invalidate_unit_tb: errors");
		$finish;
	end
endmodule
